// File: src/c_like_token_scanner_macros.svh
// Assertion macros shared by the token scanner modules.
`ifndef C_LIKE_TOKEN_SCANNER_MACROS_SVH
`define C_LIKE_TOKEN_SCANNER_MACROS_SVH

// Same-cycle implication, off during reset.
`define CTS_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define CTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cts_pkg.sv
// Shared types and constants of the token scanner.
package cts_pkg;

  localparam int CH_W   = 8;
  localparam int LEN_W  = 8;
  // Result queue depth; must be a power of two (pointers wrap by truncation).
  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    K_END     = 4'd0,
    K_ID      = 4'd1,
    K_INT     = 4'd2,
    K_FLOAT   = 4'd3,
    K_NOTEQ   = 4'd4,
    K_PUNCT   = 4'd5,
    K_PLUS    = 4'd6,
    K_MINUS   = 4'd7,
    K_STAR    = 4'd8,
    K_SLASH   = 4'd9,
    K_ASSIGN  = 4'd10,
    K_SEMI    = 4'd11,
    K_LPAREN  = 4'd12,
    K_RPAREN  = 4'd13,
    K_UNKNOWN = 4'd14
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [LEN_W-1:0] length;
    logic             last;
  } res_t;

  // Words pushed into the result queue by one accepted character.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } wr_t;

endpackage

// File: src/cts_scan.sv
// Scanner state and per-character token decode.
`include "c_like_token_scanner_macros.svh"

module cts_scan (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [cts_pkg::CH_W-1:0]  ch,
  input  logic                      is_end,
  input  logic [cts_pkg::LEN_W-1:0] max_lexeme,
  output cts_pkg::wr_t              wr
);

  typedef enum logic [2:0] {
    M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_IDENT, M_NUMBER, M_BANG
  } mode_t;

  localparam logic [7:0] C_NL     = 8'h0A;
  localparam logic [7:0] C_BANG   = 8'h21;
  localparam logic [7:0] C_LPAREN = 8'h28;
  localparam logic [7:0] C_RPAREN = 8'h29;
  localparam logic [7:0] C_STAR   = 8'h2A;
  localparam logic [7:0] C_PLUS   = 8'h2B;
  localparam logic [7:0] C_MINUS  = 8'h2D;
  localparam logic [7:0] C_DOT    = 8'h2E;
  localparam logic [7:0] C_SLASH  = 8'h2F;
  localparam logic [7:0] C_SEMI   = 8'h3B;
  localparam logic [7:0] C_EQ     = 8'h3D;
  localparam logic [7:0] C_UNDER  = 8'h5F;

  mode_t                     mode, mode_next;
  logic [cts_pkg::LEN_W-1:0] tok_len, tok_len_next;
  logic                      saw_dot, saw_dot_next;
  logic                      halted, halted_next;

  logic is_sp, is_al, is_dg, is_pu;
  mode_t                     idle_mode;
  logic [cts_pkg::LEN_W-1:0] idle_len;
  logic                      idle_emit, idle_halt;
  cts_pkg::kind_t            idle_kind;

  logic                      flush_v;
  cts_pkg::kind_t            flush_kind;
  logic [cts_pkg::LEN_W-1:0] flush_len;

  logic                      close, rescan, b_v;
  cts_pkg::kind_t            b_kind;
  logic [cts_pkg::LEN_W-1:0] b_len;
  logic                      room;

  // character classes
  always_comb begin
    is_sp = (ch == 8'h20) || (ch inside {[8'h09:8'h0D]});
    is_al = (ch inside {[8'h41:8'h5A]}) || (ch inside {[8'h61:8'h7A]});
    is_dg = ch inside {[8'h30:8'h39]};
    is_pu = (ch inside {[8'h21:8'h2F]}) || (ch inside {[8'h3A:8'h40]}) ||
            (ch inside {[8'h5B:8'h60]}) || (ch inside {[8'h7B:8'h7E]});
  end

  // what a character does when it starts fresh between tokens
  always_comb begin
    idle_mode = M_IDLE;
    idle_len  = '0;
    idle_emit = 1'b0;
    idle_halt = 1'b0;
    idle_kind = cts_pkg::K_PUNCT;
    if (is_sp) begin
      idle_mode = M_IDLE;
    end else if (ch == C_SLASH) begin
      idle_mode = M_SLASH;
    end else if (is_al || ch == C_UNDER) begin
      idle_mode = M_IDENT;
      idle_len  = cts_pkg::LEN_W'(1);
    end else if (is_dg) begin
      idle_mode = M_NUMBER;
      idle_len  = cts_pkg::LEN_W'(1);
    end else if (ch == C_BANG) begin
      idle_mode = M_BANG;
    end else begin
      idle_emit = 1'b1;
      case (ch)
        C_PLUS:   idle_kind = cts_pkg::K_PLUS;
        C_MINUS:  idle_kind = cts_pkg::K_MINUS;
        C_STAR:   idle_kind = cts_pkg::K_STAR;
        C_EQ:     idle_kind = cts_pkg::K_ASSIGN;
        C_SEMI:   idle_kind = cts_pkg::K_SEMI;
        C_LPAREN: idle_kind = cts_pkg::K_LPAREN;
        C_RPAREN: idle_kind = cts_pkg::K_RPAREN;
        default: begin
          if (is_pu) begin
            idle_kind = cts_pkg::K_PUNCT;
          end else begin
            idle_kind = cts_pkg::K_UNKNOWN;
            idle_halt = 1'b1;
          end
        end
      endcase
    end
  end

  // pending token of the current mode
  always_comb begin
    flush_v    = 1'b0;
    flush_kind = cts_pkg::K_PUNCT;
    flush_len  = cts_pkg::LEN_W'(1);
    case (mode)
      M_SLASH: begin
        flush_v    = 1'b1;
        flush_kind = cts_pkg::K_SLASH;
      end
      M_IDENT: begin
        flush_v    = 1'b1;
        flush_kind = cts_pkg::K_ID;
        flush_len  = tok_len;
      end
      M_NUMBER: begin
        flush_v    = 1'b1;
        flush_kind = saw_dot ? cts_pkg::K_FLOAT : cts_pkg::K_INT;
        flush_len  = tok_len;
      end
      M_BANG: begin
        flush_v    = 1'b1;
        flush_kind = cts_pkg::K_PUNCT;
      end
      default: flush_v = 1'b0;
    endcase
  end

  assign room = tok_len < max_lexeme;

  always_comb begin
    mode_next    = mode;
    tok_len_next = tok_len;
    saw_dot_next = saw_dot;
    halted_next  = halted;
    close        = 1'b0;
    rescan       = 1'b0;
    b_v          = 1'b0;
    b_kind       = cts_pkg::K_END;
    b_len        = '0;
    if (!halted) begin
      if (is_end) begin
        close        = 1'b1;
        b_v          = 1'b1;
        halted_next  = 1'b1;
        mode_next    = M_IDLE;
        tok_len_next = '0;
        saw_dot_next = 1'b0;
      end else begin
        case (mode)
          M_SLASH: begin
            if (ch == C_SLASH) begin
              mode_next = M_LINE;
            end else if (ch == C_STAR) begin
              mode_next = M_BLOCK;
            end else begin
              close  = 1'b1;
              rescan = 1'b1;
            end
          end
          M_LINE: begin
            if (ch == C_NL) mode_next = M_IDLE;
          end
          M_BLOCK: begin
            if (ch == C_STAR) mode_next = M_BSTAR;
          end
          M_BSTAR: begin
            if (ch == C_SLASH) begin
              mode_next = M_IDLE;
            end else if (ch != C_STAR) begin
              mode_next = M_BLOCK;
            end
          end
          M_IDENT: begin
            if ((is_al || is_dg || ch == C_UNDER) && room) begin
              tok_len_next = tok_len + cts_pkg::LEN_W'(1);
            end else begin
              close  = 1'b1;
              rescan = 1'b1;
            end
          end
          M_NUMBER: begin
            if ((is_dg || ch == C_DOT) && room) begin
              tok_len_next = tok_len + cts_pkg::LEN_W'(1);
              if (ch == C_DOT) saw_dot_next = 1'b1;
            end else begin
              close  = 1'b1;
              rescan = 1'b1;
            end
          end
          M_BANG: begin
            if (ch == C_EQ) begin
              b_v       = 1'b1;
              b_kind    = cts_pkg::K_NOTEQ;
              b_len     = cts_pkg::LEN_W'(2);
              mode_next = M_IDLE;
            end else begin
              close  = 1'b1;
              rescan = 1'b1;
            end
          end
          default: rescan = 1'b1;
        endcase
        if (rescan) begin
          mode_next    = idle_mode;
          tok_len_next = idle_len;
          saw_dot_next = 1'b0;
          halted_next  = idle_halt;
          b_v          = idle_emit;
          b_kind       = idle_kind;
          b_len        = cts_pkg::LEN_W'(1);
        end
      end
    end
  end

  // pack up to two words; the later one carries last
  always_comb begin
    wr = '0;
    if (accept) begin
      if (close && flush_v && b_v) begin
        wr.n  = 2'd2;
        wr.r0 = '{kind: flush_kind, length: flush_len, last: 1'b0};
        wr.r1 = '{kind: b_kind, length: b_len, last: 1'b1};
      end else if (close && flush_v) begin
        wr.n  = 2'd1;
        wr.r0 = '{kind: flush_kind, length: flush_len, last: 1'b1};
      end else if (b_v) begin
        wr.n  = 2'd1;
        wr.r0 = '{kind: b_kind, length: b_len, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      tok_len <= '0;
      saw_dot <= 1'b0;
      halted  <= 1'b0;
    end else if (accept) begin
      mode    <= mode_next;
      tok_len <= tok_len_next;
      saw_dot <= saw_dot_next;
      halted  <= halted_next;
    end
  end

  `CTS_ASSERT_NEXT(a_halt_sticky, clk, rst, halted, halted, "halt flag dropped")
  `CTS_ASSERT(a_halt_quiet, clk, rst, halted, wr.n == 2'd0, "word pushed while halted")
  `CTS_ASSERT_NEXT(a_end_halts, clk, rst, accept && is_end, halted, "end marker did not halt")

endmodule

// File: src/cts_outq.sv
// Small result queue taking up to two words per cycle.
`include "c_like_token_scanner_macros.svh"

module cts_outq (
  input  logic                      clk,
  input  logic                      rst,
  input  cts_pkg::wr_t              wr,
  output logic                      room,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [3:0]                kind,
  output logic [cts_pkg::LEN_W-1:0] length,
  output logic                      last
);

  cts_pkg::res_t               q [cts_pkg::QDEPTH];
  logic [cts_pkg::PTR_W-1:0]   wptr, rptr;
  logic [cts_pkg::CNT_W-1:0]   count;
  logic                        pop;

  // room for the two words one character can produce
  assign room      = count <= cts_pkg::CNT_W'(cts_pkg::QDEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign kind      = q[rptr].kind;
  assign length    = q[rptr].length;
  assign last      = q[rptr].last;

  always_ff @(posedge clk) begin
    if (wr.n != 2'd0) q[wptr] <= wr.r0;
    if (wr.n == 2'd2) q[wptr + cts_pkg::PTR_W'(1)] <= wr.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + cts_pkg::PTR_W'(wr.n);
      rptr  <= rptr + cts_pkg::PTR_W'(pop);
      count <= count + cts_pkg::CNT_W'(wr.n) - cts_pkg::CNT_W'(pop);
    end
  end

  `CTS_ASSERT(a_cnt_bound, clk, rst, 1'b1, count <= cts_pkg::CNT_W'(cts_pkg::QDEPTH), "queue overfull")
  `CTS_ASSERT(a_push_room, clk, rst, wr.n != 2'd0, room, "push without room")

endmodule

// File: src/c_like_token_scanner.sv
// A token word enters the result queue as the character closing it is accepted.
// Throughput: one character per cycle; each makes zero to two words into a four-word queue,
//   and in_ready drops while fewer than two queue slots are free.
// Reset (rst, synchronous): scanner idle between tokens, queue empty, max_lexeme = 255.
// After an end marker or an unknown character the scanner halts until reset.
module c_like_token_scanner (
  input  logic                      clk,
  input  logic                      rst,
  // character channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cts_pkg::CH_W-1:0]  ch,
  input  logic                      is_end,
  // token word channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [3:0]                kind,
  output logic [cts_pkg::LEN_W-1:0] length,
  output logic                      last,
  // max_lexeme register write
  input  logic                      cfg_we,
  input  logic [cts_pkg::LEN_W-1:0] cfg_wdata
);

  logic [cts_pkg::LEN_W-1:0] max_lexeme;
  logic                      accept;
  logic                      room;
  cts_pkg::wr_t              wr;

  // Longest token; a continuing character past it starts a new token.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_lexeme <= 8'd255;
    end else if (cfg_we) begin
      max_lexeme <= cfg_wdata;
    end
  end

  // A character is taken whenever the queue can absorb its worst case of two words,
  // so the word side stalling never blocks the scanner until the queue backs up.
  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  // Mode update and character decode; pushes words the same cycle.
  cts_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .ch         (ch),
    .is_end     (is_end),
    .max_lexeme (max_lexeme),
    .wr         (wr)
  );

  // Result queue acts as the output register.
  cts_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .length    (length),
    .last      (last)
  );

endmodule

// File: sim/tb_c_like_token_scanner.sv
// Self-checking testbench for the C-like token scanner: directed text, random text, stalls.
`timescale 1ns / 1ps

module tb_c_like_token_scanner;

  // Generous cap on run length.
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  // Scanner modes as the testbench tracks them.
  typedef enum logic [2:0] {
    SM_IDLE, SM_SLASH, SM_LINE, SM_BLOCK, SM_BSTAR, SM_IDENT, SM_NUMBER, SM_BANG
  } scan_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // character channel
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [cts_pkg::CH_W-1:0]  ch = '0;
  logic                      is_end = 1'b0;
  // token word channel
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [3:0]                kind;
  logic [cts_pkg::LEN_W-1:0] length;
  logic                      last;
  // max_lexeme write port
  logic                      cfg_we = 1'b0;
  logic [cts_pkg::LEN_W-1:0] cfg_wdata = '0;

  // Our own copy of the scanner state; reset values match the block's.
  scan_mode_t mode_q   = SM_IDLE;
  logic [7:0] tok_len  = '0;
  logic       dot_seen = 1'b0;
  logic       stopped  = 1'b0;
  logic [7:0] max_len  = 8'd255;

  // Token words the block still owes us, oldest first.
  cts_pkg::res_t pending_tokens[$];
  // The newest word of the character being scanned is held back so its last flag can be set.
  cts_pkg::res_t held_word;
  logic held_valid = 1'b0;

  int mismatches    = 0;
  int words_sent    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;

  string single_ops = "+-*=;()!/";

  c_like_token_scanner i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .is_end    (is_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .length    (length),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Queue one token word; the previously held word is now known not to be last.
  function automatic void add_token(input cts_pkg::kind_t k, input logic [7:0] n);
    if (held_valid) pending_tokens.push_back(held_word);
    held_word.kind   = k;
    held_word.length = n;
    held_word.last   = 1'b0;
    held_valid       = 1'b1;
  endfunction

  // Emit whatever token is open and go back to idle.
  function automatic void close_token();
    case (mode_q)
      SM_SLASH:  add_token(cts_pkg::K_SLASH, 8'd1);
      SM_IDENT:  add_token(cts_pkg::K_ID, tok_len);
      SM_NUMBER: add_token(dot_seen ? cts_pkg::K_FLOAT : cts_pkg::K_INT, tok_len);
      SM_BANG:   add_token(cts_pkg::K_PUNCT, 8'd1);
      default: ;
    endcase
    mode_q   = SM_IDLE;
    tok_len  = '0;
    dot_seen = 1'b0;
  endfunction

  // Scan a character from idle: skip blanks, open a token, or emit a one-char token.
  function automatic void start_token(input logic [7:0] c);
    mode_q   = SM_IDLE;
    tok_len  = '0;
    dot_seen = 1'b0;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      // whitespace, nothing to do
    end else if (c == "/") begin
      mode_q = SM_SLASH;
    end else if (is_letter(c) || c == "_") begin
      mode_q  = SM_IDENT;
      tok_len = 8'd1;
    end else if (is_digit(c)) begin
      mode_q  = SM_NUMBER;
      tok_len = 8'd1;
    end else if (c == "!") begin
      mode_q = SM_BANG;
    end else begin
      case (c)
        "+": add_token(cts_pkg::K_PLUS, 8'd1);
        "-": add_token(cts_pkg::K_MINUS, 8'd1);
        "*": add_token(cts_pkg::K_STAR, 8'd1);
        "=": add_token(cts_pkg::K_ASSIGN, 8'd1);
        ";": add_token(cts_pkg::K_SEMI, 8'd1);
        "(": add_token(cts_pkg::K_LPAREN, 8'd1);
        ")": add_token(cts_pkg::K_RPAREN, 8'd1);
        default: begin
          if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
              (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126)) begin
            add_token(cts_pkg::K_PUNCT, 8'd1);
          end else begin
            // control byte, DEL or high byte: unknown, and the scanner stops for good
            add_token(cts_pkg::K_UNKNOWN, 8'd1);
            stopped = 1'b1;
          end
        end
      endcase
    end
  endfunction

  // Grow an identifier or number, or split it once it has hit max_len.
  // A max_len of zero never lets a token grow, so it acts like one.
  function automatic void extend_token(input logic [7:0] c, input logic grows);
    if (grows && tok_len < max_len) begin
      tok_len = tok_len + 8'd1;
      if (mode_q == SM_NUMBER && c == ".") dot_seen = 1'b1;
    end else begin
      close_token();
      start_token(c);
    end
  endfunction

  // Work out the token words one accepted character causes and queue them.
  function automatic void scan_char(input logic [7:0] c, input logic end_mark);
    if (!stopped) begin
      if (end_mark) begin
        close_token();
        add_token(cts_pkg::K_END, 8'd0);
        stopped = 1'b1;
      end else begin
        case (mode_q)
          SM_SLASH: begin
            if (c == "/") mode_q = SM_LINE;
            else if (c == "*") mode_q = SM_BLOCK;
            else begin
              // lone slash: emit it, then scan c normally
              close_token();
              start_token(c);
            end
          end
          SM_LINE:   if (c == CH_NEWLINE) mode_q = SM_IDLE;
          SM_BLOCK:  if (c == "*") mode_q = SM_BSTAR;
          SM_BSTAR: begin
            // any run of stars followed by a slash closes the comment
            if (c == "/") mode_q = SM_IDLE;
            else if (c != "*") mode_q = SM_BLOCK;
          end
          SM_IDENT:  extend_token(c, is_letter(c) || is_digit(c) || c == "_");
          SM_NUMBER: extend_token(c, is_digit(c) || c == ".");
          SM_BANG: begin
            if (c == "=") begin
              // not-equal is always two long, whatever max_len says
              add_token(cts_pkg::K_NOTEQ, 8'd2);
              mode_q = SM_IDLE;
            end else begin
              close_token();
              start_token(c);
            end
          end
          default: start_token(c);
        endcase
      end
    end
    if (held_valid) begin
      held_word.last = 1'b1;
      pending_tokens.push_back(held_word);
      held_valid = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one character word and wait until it is taken. Valid is left high on
  // return so a back-to-back word needs no second assignment in the same step.
  task automatic send_word(input logic [7:0] c, input logic end_mark);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    is_end   <= end_mark;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scan_char(c, end_mark);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // Drop valid and wait for every owed word, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, only with the block quiet.
  task automatic set_max_len(input logic [7:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    max_len = v;
  endtask

  // Feed whatever characters bring the scanner back to idle, so a comment or a
  // long token that follows starts cleanly.
  task automatic settle_idle();
    while (mode_q != SM_IDLE) begin
      case (mode_q)
        SM_LINE:  send_word(CH_NEWLINE, 1'b0);
        SM_BLOCK: send_word("*", 1'b0);
        SM_BSTAR: send_word("/", 1'b0);
        default:  send_word(" ", 1'b0);
      endcase
    end
  endtask

  // Any byte, including control and high bytes, that keeps the current comment open.
  function automatic logic [7:0] comment_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((mode_q == SM_LINE && b == CH_NEWLINE) || (mode_q == SM_BSTAR && b == "/"));
    return b;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // Identifier character; a leading one is never a digit.
  function automatic logic [7:0] ident_char(input logic lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  task automatic send_ident(input int n);
    send_word(ident_char(1'b1), 1'b0);
    repeat (n - 1) send_word(ident_char(1'b0), 1'b0);
  endtask

  // One random lexical piece. Pieces run into each other with no forced blanks,
  // so merges and splits between tokens come up on their own.
  task automatic send_random_piece();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    n   = $urandom_range(1, 10);
    if (sel < 25) begin
      send_ident(n);
    end else if (sel < 40) begin
      send_word(rand_digit(), 1'b0);
      repeat ($urandom_range(0, 7)) begin
        if ($urandom_range(0, 99) < 15) send_word(".", 1'b0);
        else send_word(rand_digit(), 1'b0);
      end
    end else if (sel < 58) begin
      send_word(single_ops[$urandom_range(0, single_ops.len() - 1)], 1'b0);
    end else if (sel < 62) begin
      send_text("!=");
    end else if (sel < 75) begin
      repeat ($urandom_range(1, 3)) begin
        n = $urandom_range(8, 13);
        send_word((n == 8) ? 8'd32 : 8'(n), 1'b0);
      end
    end else if (sel < 80) begin
      settle_idle();
      send_text("//");
      repeat (n) send_word(comment_byte(), 1'b0);
      send_word(CH_NEWLINE, 1'b0);
    end else if (sel < 85) begin
      settle_idle();
      send_text("/*");
      repeat (n) begin
        if ($urandom_range(0, 99) < 15) send_word("*", 1'b0);
        else send_word(comment_byte(), 1'b0);
      end
      repeat ($urandom_range(1, 3)) send_word("*", 1'b0);
      send_word("/", 1'b0);
    end else begin
      // noise: any printable or blank, which may also open a comment by chance
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 99) < 10) send_word(8'($urandom_range(9, 13)), 1'b0);
        else send_word(8'($urandom_range(32, 126)), 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Each token word taken from the block is compared with the oldest owed one.
  always @(posedge clk) begin : check_words
    cts_pkg::res_t owed;
    if (!rst && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected word: kind %0d length %0d last %0d", kind, length, last);
        mismatches++;
      end else begin
        owed = pending_tokens.pop_front();
        if (kind !== owed.kind) begin
          $error("kind: expected %0d, got %0d", owed.kind, kind);
          mismatches++;
        end
        if (length !== owed.length) begin
          $error("length: expected %0d, got %0d", owed.length, length);
          mismatches++;
        end
        if (last !== owed.last) begin
          $error("last: expected %0d, got %0d", owed.last, last);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every token kind but integer, end and unknown: an underscore identifier, a float closed
  // by "!=", a lone bang, a lone slash, and each single operator.
  task automatic test_tokens_and_operators();
    send_text("_9 3.5!=!/+-*=;()");
  endtask

  // Block comment closed by a star run, line comment; bytes 0x00 and 0xFF inside.
  task automatic test_comments();
    send_text("/*");
    send_word(8'h00, 1'b0);
    send_text("**/");
    send_text("//");
    send_word(8'hFF, 1'b0);
    send_word(CH_NEWLINE, 1'b0);
  endtask

  // Lower the limit below the open number's length: it closes at its current
  // length on the next digit.
  task automatic test_max_lexeme_lowered();
    send_text("12");
    set_max_len(8'd1);
    send_text("3 ");
  endtask

  // A limit of zero splits every character into its own token.
  task automatic test_max_lexeme_zero();
    set_max_len(8'd0);
    send_text("a_;");
  endtask

  // Identifier and number one and two past the 255 limit.
  task automatic test_long_tokens();
    int dot_at;
    dot_at = $urandom_range(1, 254);
    settle_idle();
    send_ident(256);
    send_word(" ", 1'b0);
    for (int i = 0; i < 257; i++) send_word((i == dot_at) ? 8'(".") : rand_digit(), 1'b0);
    send_word(" ", 1'b0);
  endtask

  task automatic test_random_text(input int n);
    int stop_at;
    stop_at = words_sent + n;
    while (words_sent < stop_at) send_random_piece();
  endtask

  // Receiver holds off while operators keep coming: the result queue fills and
  // in_ready must drop. Then the sender waits for every word before going on.
  task automatic test_output_stall();
    settle_idle();
    hold_left = 60;
    repeat (16) send_word(single_ops[$urandom_range(0, 6)], 1'b0);
    wait_drained();
  endtask

  // Finish the text one of four ways, then check that a stopped scanner stays silent.
  task automatic test_end_of_text();
    int         pick;
    logic [7:0] bad;
    pick = $urandom_range(0, 3);
    settle_idle();
    case (pick)
      0: begin
        // pending identifier flushed ahead of the end word
        send_ident(3);
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
      1: begin
        // unterminated block comment is simply dropped
        send_text("/*");
        repeat (3) send_word(comment_byte(), 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        // unknown byte after a pending identifier
        case ($urandom_range(0, 3))
          0:       bad = 8'($urandom_range(0, 8));
          1:       bad = 8'($urandom_range(14, 31));
          2:       bad = 8'd127;
          default: bad = 8'($urandom_range(128, 255));
        endcase
        send_ident(2);
        send_word(bad, 1'b0);
      end
      default: begin
        // lone slash flushed by the end marker
        send_word("/", 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
    send_word(8'($urandom_range(0, 255)), 1'b1);
    repeat (5) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_tokens_and_operators();
    test_comments();
    test_max_lexeme_lowered();
    test_max_lexeme_zero();

    // sender gaps 29%, receiver stalls 50%, full-length limit
    send_idle_pct = 29;
    recv_idle_pct = 50;
    set_max_len(8'd255);
    test_long_tokens();
    test_random_text(300);

    // roles swapped, every identifier and number cut to one character
    send_idle_pct = 50;
    recv_idle_pct = 29;
    set_max_len(8'd1);
    test_random_text(300);

    // no idling at all, a short random limit
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_max_len(8'($urandom_range(2, 12)));
    test_random_text(300);
    test_output_stall();

    test_end_of_text();
    wait_drained();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
